[design/mlcs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mlcs_pkg
// Shared constants and types of the mask line contour scan unit: frame and
// probe line geometry, register indexes, reset values and the frame summary
// word that travels from the front part to the point sequencer.
// ----------------------------------------------------------------------------
package mlcs_pkg;

    // frame geometry
    localparam int MAX_DIM   = 4096;
    localparam int H_LINES   = 4;
    localparam int V_LINES   = 5;
    localparam int NUM_LINES = H_LINES + V_LINES;

    localparam int COORD_W    = $clog2(MAX_DIM);
    localparam int DIM_W      = COORD_W + 1;
    localparam int PIX_W      = 8;
    localparam int LINE_NUM_W = 3;
    localparam int LINE_IDX_W = $clog2(NUM_LINES);

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = DIM_W;

    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_WIDTH  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_HEIGHT = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] CFG_FG_THRESHOLD = CFG_ADDR_W'(2);

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = DIM_W'(640);
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = DIM_W'(480);
    localparam logic [PIX_W-1:0] FG_THRESHOLD_RST = PIX_W'(127);

    // size limits after saturation
    localparam logic [DIM_W-1:0] MIN_WIDTH  = DIM_W'(V_LINES + 1);
    localparam logic [DIM_W-1:0] MIN_HEIGHT = DIM_W'(H_LINES + 1);
    localparam logic [DIM_W-1:0] DIM_LIMIT  = DIM_W'(MAX_DIM);

    // probe spacing by reciprocal multiply, exact for every dimension up to 2**DIM_W
    localparam int H_DIV       = H_LINES + 1;
    localparam int V_DIV       = V_LINES + 1;
    localparam int RECIP_SHIFT = DIM_W + 4;
    localparam int H_RECIP     = ((2 ** RECIP_SHIFT) + H_DIV - 1) / H_DIV;
    localparam int V_RECIP     = ((2 ** RECIP_SHIFT) + V_DIV - 1) / V_DIV;
    localparam int PROD_W      = DIM_W + RECIP_SHIFT;

    // summary queue depth, a power of two
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // one probe line: its position and the near and far foreground hits
    typedef struct packed {
        logic [COORD_W-1:0] pos;
        logic [COORD_W-1:0] near;
        logic [COORD_W-1:0] far;
    } t_line;

    // one finished frame: rows first, then columns
    typedef struct packed {
        logic [NUM_LINES-1:0]  found;
        t_line [NUM_LINES-1:0] lines;
    } t_summary;

endpackage
`default_nettype wire

[design/mask_line_contour_scan_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mask_line_contour_scan_unit
// Scans segmented mask frames along fixed probe rows and columns and reports
// the near and far foreground pixel of every hit probe line at each frame end.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on push/full, one word per cycle unless
//   full; frame position is tracked inside from frame_width and frame_height.
//   Points leave on empty/pop, rows first then columns, near end before far
//   end; the frame's final point carries o_last_point. A frame without
//   foreground on any probe line gives no words at all.
//   Throughput is one pixel per cycle unless full; points leave at one per
//   cycle while pop is held. After its last pixel is taken, the first point
//   of a frame reaches the outputs through the first and second front
//   stages, the summary queue write, then the point sequencer's output register.
//   Finished frames wait in a two entry summary queue. full rises only when a
//   frame ends while that queue holds two frames not yet read out, so a
//   stalled receiver holds the pixel side only after about two frames.
//   Configuration takes effect on the next pixel; write only while idle.
//   Reset (synchronous, active low) restores the default registers, restarts
//   the frame at its first pixel and drops any pending points.
// ----------------------------------------------------------------------------
module mask_line_contour_scan_unit import mlcs_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [PIX_W-1:0]      i_pixel_value,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [COORD_W-1:0]         o_point_x,
    output logic [COORD_W-1:0]         o_point_y,
    output logic                       o_line_kind,
    output logic [LINE_NUM_W-1:0]      o_line_number,
    output logic                       o_end_side,
    output logic                       o_last_point
);

    logic     q_wr;
    logic     q_rd;
    logic     q_full;
    logic     q_empty;
    t_summary q_wr_data;
    t_summary q_rd_data;

    // classification and hit tracking
    mlcs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_push        (push),
        .i_pixel_value (i_pixel_value),
        .o_full        (full),
        .i_q_full      (q_full),
        .o_q_wr        (q_wr),
        .o_q_data      (q_wr_data)
    );

    // frame summary queue
    mlcs_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_data (q_wr_data),
        .i_rd      (q_rd),
        .o_full    (q_full),
        .o_empty   (q_empty),
        .o_rd_data (q_rd_data)
    );

    // point sequencer
    mlcs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_data      (q_rd_data),
        .o_q_pop       (q_rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .o_line_kind   (o_line_kind),
        .o_line_number (o_line_number),
        .o_end_side    (o_end_side),
        .o_last_point  (o_last_point)
    );

endmodule
`default_nettype wire

[design/mlcs_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mlcs_front
// Front part: configuration registers, raster position tracking, foreground
// classification, probe spacing and per line hit tracking. At the last pixel
// of a frame it writes the frame summary into the queue, unless no line was hit.
// ----------------------------------------------------------------------------
module mlcs_front import mlcs_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_push,
    input  wire logic [PIX_W-1:0]      i_pixel_value,
    output logic                       o_full,
    input  wire logic                  i_q_full,
    output logic                       o_q_wr,
    output t_summary                   o_q_data
);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] lo);
        logic [DIM_W-1:0] res;
        res = v;
        if (v < lo) begin
            res = lo;
        end else if (v > DIM_LIMIT) begin
            res = DIM_LIMIT;
        end
        return res;
    endfunction

    logic [DIM_W-1:0]   r_frame_width;
    logic [DIM_W-1:0]   r_frame_height;
    logic [PIX_W-1:0]   r_fg_threshold;
    logic [COORD_W-1:0] r_col;
    logic [COORD_W-1:0] r_row;

    logic               r_s1_valid;
    logic               r_s1_fg;
    logic               r_s1_eof;
    logic [COORD_W-1:0] r_s1_col;
    logic [COORD_W-1:0] r_s1_row;
    logic [DIM_W-1:0]   r_s1_w;
    logic [DIM_W-1:0]   r_s1_h;

    logic               r_s2_valid;
    logic               r_s2_fg;
    logic               r_s2_eof;
    logic [COORD_W-1:0] r_s2_col;
    logic [COORD_W-1:0] r_s2_row;
    logic [COORD_W-1:0] r_s2_hstep;
    logic [COORD_W-1:0] r_s2_vstep;

    logic [NUM_LINES-1:0] r_found;
    logic [NUM_LINES-1:0] n_found;
    logic [COORD_W-1:0]   r_near [NUM_LINES];
    logic [COORD_W-1:0]   r_far  [NUM_LINES];
    logic [COORD_W-1:0]   n_near [NUM_LINES];
    logic [COORD_W-1:0]   n_far  [NUM_LINES];
    logic [COORD_W-1:0]   line_pos [NUM_LINES];
    logic [NUM_LINES-1:0] line_hit;

    logic [DIM_W-1:0]   width_sat;
    logic [DIM_W-1:0]   height_sat;
    logic               row_end;
    logic               frame_end;
    logic               accept;
    logic               advance;
    logic               eof_step;
    logic [PROD_W-1:0]  h_prod;
    logic [PROD_W-1:0]  v_prod;
    logic [COORD_W-1:0] hstep;
    logic [COORD_W-1:0] vstep;

    // configuration writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_fg_threshold <= FG_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata;
                CFG_FG_THRESHOLD: r_fg_threshold <= i_cfg_wdata[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // stall only when a frame summary meets a full queue
    assign eof_step = r_s2_valid && r_s2_eof;
    assign advance  = !(eof_step && (|n_found) && i_q_full);
    assign o_full   = !advance;
    assign accept   = i_push && advance;

    // raster position and row and frame ends
    assign width_sat  = clamp_dim(r_frame_width, MIN_WIDTH);
    assign height_sat = clamp_dim(r_frame_height, MIN_HEIGHT);
    assign row_end    = ({1'b0, r_col} + DIM_W'(1)) >= width_sat;
    assign frame_end  = row_end && (({1'b0, r_row} + DIM_W'(1)) >= height_sat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (row_end) begin
                r_col <= '0;
                if (frame_end) begin
                    r_row <= '0;
                end else begin
                    r_row <= r_row + COORD_W'(1);
                end
            end else begin
                r_col <= r_col + COORD_W'(1);
            end
        end
    end

    // probe spacing from the sizes that came with the pixel
    assign h_prod = PROD_W'(r_s1_h) * PROD_W'(H_RECIP);
    assign v_prod = PROD_W'(r_s1_w) * PROD_W'(V_RECIP);
    assign hstep  = h_prod[RECIP_SHIFT +: COORD_W];
    assign vstep  = v_prod[RECIP_SHIFT +: COORD_W];

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_fg    <= i_pixel_value > r_fg_threshold;
            r_s1_eof   <= frame_end;
            r_s1_col   <= r_col;
            r_s1_row   <= r_row;
            r_s1_w     <= width_sat;
            r_s1_h     <= height_sat;
            r_s2_fg    <= r_s1_fg;
            r_s2_eof   <= r_s1_eof;
            r_s2_col   <= r_s1_col;
            r_s2_row   <= r_s1_row;
            r_s2_hstep <= hstep;
            r_s2_vstep <= vstep;
        end
    end

    // probe line positions and hits, rows then columns
    always_comb begin
        for (int k = 0; k < NUM_LINES; k++) begin
            if (k < H_LINES) begin
                line_pos[k] = COORD_W'(r_s2_hstep * COORD_W'(k + 1));
                line_hit[k] = r_s2_fg && (r_s2_row == line_pos[k]);
                n_near[k]   = (line_hit[k] && !r_found[k]) ? r_s2_col : r_near[k];
                n_far[k]    = line_hit[k] ? r_s2_col : r_far[k];
            end else begin
                line_pos[k] = COORD_W'(r_s2_vstep * COORD_W'(k - H_LINES + 1));
                line_hit[k] = r_s2_fg && (r_s2_col == line_pos[k]);
                n_near[k]   = (line_hit[k] && !r_found[k]) ? r_s2_row : r_near[k];
                n_far[k]    = line_hit[k] ? r_s2_row : r_far[k];
            end
            n_found[k] = r_found[k] | line_hit[k];
        end
    end

    // hit tracking, found flags cleared at each frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= '0;
        end else if (r_s2_valid && advance) begin
            r_found <= r_s2_eof ? '0 : n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid && advance) begin
            for (int k = 0; k < NUM_LINES; k++) begin
                r_near[k] <= n_near[k];
                r_far[k]  <= n_far[k];
            end
        end
    end

    // frame summary toward the queue, empty frames are dropped
    assign o_q_wr = eof_step && (|n_found) && advance;

    always_comb begin
        o_q_data.found = n_found;
        for (int k = 0; k < NUM_LINES; k++) begin
            o_q_data.lines[k].pos  = line_pos[k];
            o_q_data.lines[k].near = n_near[k];
            o_q_data.lines[k].far  = n_far[k];
        end
    end

endmodule
`default_nettype wire

[design/mlcs_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mlcs_fifo
// Short queue of frame summaries between the front part and the point
// sequencer, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module mlcs_fifo import mlcs_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_wr,
    input  wire t_summary  i_wr_data,
    input  wire logic      i_rd,
    output logic           o_full,
    output logic           o_empty,
    output t_summary       o_rd_data
);

    t_summary                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   r_wr_ptr;
    logic [FIFO_PTR_W-1:0]   r_rd_ptr;
    logic [FIFO_CNT_W-1:0]   r_count;

    assign o_full    = r_count == FIFO_CNT_W'(FIFO_DEPTH);
    assign o_empty   = r_count == '0;
    assign o_rd_data = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + FIFO_CNT_W'(1);
            end else if (i_rd && !i_wr) begin
                r_count <= r_count - FIFO_CNT_W'(1);
            end
        end
    end

    // no write into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> (!o_full || i_rd))
        else $error("summary queue overflow");

    // no read from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> !o_empty)
        else $error("summary queue underflow");

    // fill level never passes the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("summary queue count out of range");

endmodule
`default_nettype wire

[design/mlcs_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mlcs_back
// Point sequencer: walks the found lines of the queue head, near end then far
// end of each, into an output register, one point a cycle while that register is empty or popped.
// ----------------------------------------------------------------------------
module mlcs_back import mlcs_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_q_empty,
    input  wire t_summary              i_q_data,
    output logic                       o_q_pop,
    input  wire logic                  i_pop,
    output logic                       o_empty,
    output logic [COORD_W-1:0]         o_point_x,
    output logic [COORD_W-1:0]         o_point_y,
    output logic                       o_line_kind,
    output logic [LINE_NUM_W-1:0]      o_line_number,
    output logic                       o_end_side,
    output logic                       o_last_point
);

    logic [NUM_LINES-1:0]  r_done;
    logic                  r_side;
    logic                  r_out_valid;
    logic [COORD_W-1:0]    r_point_x;
    logic [COORD_W-1:0]    r_point_y;
    logic                  r_line_kind;
    logic [LINE_NUM_W-1:0] r_line_number;
    logic                  r_end_side;
    logic                  r_last_point;

    logic [NUM_LINES-1:0]  pending;
    logic [NUM_LINES-1:0]  cur_onehot;
    logic [NUM_LINES-1:0]  rest;
    logic [LINE_IDX_W-1:0] cur_idx;
    t_line                 cur_line;
    logic [COORD_W-1:0]    coord;
    logic                  is_col;
    logic                  load;
    logic                  entry_done;

    // pick the lowest line not yet emitted
    assign pending    = i_q_data.found & ~r_done;
    assign cur_onehot = pending & (~pending + NUM_LINES'(1));
    assign rest       = pending & ~cur_onehot;

    always_comb begin
        cur_idx  = '0;
        cur_line = i_q_data.lines[0];
        for (int k = 0; k < NUM_LINES; k++) begin
            if (cur_onehot[k]) begin
                cur_idx  = LINE_IDX_W'(k);
                cur_line = i_q_data.lines[k];
            end
        end
    end

    assign is_col = cur_idx >= LINE_IDX_W'(H_LINES);
    assign coord  = r_side ? cur_line.far : cur_line.near;

    // one point a cycle while the output register frees up
    assign load       = !i_q_empty && (!r_out_valid || i_pop);
    assign entry_done = load && r_side && (rest == '0);
    assign o_q_pop    = entry_done;

    // line walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
            r_side <= 1'b0;
        end else if (load) begin
            r_side <= !r_side;
            if (r_side) begin
                r_done <= entry_done ? '0 : (r_done | cur_onehot);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_point_x     <= is_col ? cur_line.pos : coord;
            r_point_y     <= is_col ? coord : cur_line.pos;
            r_line_kind   <= is_col;
            r_line_number <= is_col ? LINE_NUM_W'(cur_idx - LINE_IDX_W'(H_LINES))
                                    : LINE_NUM_W'(cur_idx);
            r_end_side    <= r_side;
            r_last_point  <= entry_done;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_point_x     = r_point_x;
    assign o_point_y     = r_point_y;
    assign o_line_kind   = r_line_kind;
    assign o_line_number = r_line_number;
    assign o_end_side    = r_end_side;
    assign o_last_point  = r_last_point;

    // a queued summary always holds at least one line
    a_head_not_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_empty |-> (i_q_data.found != '0))
        else $error("blank frame summary in queue");

    // lines marked done all belong to the head summary
    a_done_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_empty |-> ((r_done & ~i_q_data.found) == '0))
        else $error("done mask outside found lines");

    // a summary is retired on a far end and the walk restarts clean
    a_pop_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_done == '0) && !r_side && r_out_valid && r_last_point)
        else $error("summary retired out of order");

endmodule
`default_nettype wire
